>>> hdl/dlms_pkg.sv
// dlms_pkg: shared types, field widths and defaults for the dfa longest-match scanner
// no dependencies; compile first
`default_nettype none

package dlms_pkg;

    // field widths of the item and result transactions
    localparam int OP_W        = 2;
    localparam int STATE_IDX_W = 8;
    localparam int CLASS_IDX_W = 6;
    localparam int VALUE_W     = 9;
    localparam int BYTE_W      = 8;
    localparam int TAG_W       = 8;
    localparam int OUT_OFF_W   = 16;

    // default sizing
    localparam int DEF_NUM_STATES  = 256;
    localparam int DEF_NUM_CLASSES = 64;
    localparam int DEF_OFFSET_BITS = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_TRANS  = 2'd0,
        OP_LOAD_ACCEPT = 2'd1,
        OP_LOAD_CLASS  = 2'd2,
        OP_SCAN        = 2'd3
    } t_op;

    // one pipeline slot handed to the match tracker
    typedef struct packed {
        logic               valid;
        logic               step;     // a transition into a state was taken
        logic               end_run;  // run closes, a result is due
        logic [VALUE_W-1:0] acc;      // accept entry of the entered state, sign bit = none
    } t_trk_cmd;

endpackage

`default_nettype wire

>>> hdl/dlms_if.sv
// dlms_in_if / dlms_out_if: valid-ready channels of the dfa longest-match scanner
// depends on dlms_pkg for the payload widths
`default_nettype none

interface dlms_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [dlms_pkg::OP_W-1:0]            operation;
    logic [dlms_pkg::STATE_IDX_W-1:0]     state_index;
    logic [dlms_pkg::CLASS_IDX_W-1:0]     class_index;
    logic signed [dlms_pkg::VALUE_W-1:0]  table_value;
    logic [dlms_pkg::BYTE_W-1:0]          data_byte;

    modport source (output valid, operation, state_index, class_index, table_value,
                    data_byte, input ready);
    modport sink   (input valid, operation, state_index, class_index, table_value,
                    data_byte, output ready);
endinterface

interface dlms_out_if;
    logic                              valid;
    logic                              ready;
    logic                              matched;
    logic [dlms_pkg::TAG_W-1:0]        pattern_tag;
    logic [dlms_pkg::OUT_OFF_W-1:0]    match_end_offset;

    modport source (output valid, matched, pattern_tag, match_end_offset, input ready);
    modport sink   (input valid, matched, pattern_tag, match_end_offset, output ready);
endinterface

`default_nettype wire

>>> hdl/dlms_tracker.sv
// dlms_tracker: longest-match record, run offset counter and result output register
// depends on dlms_pkg and dlms_if
`default_nettype none

module dlms_tracker #(
    parameter int OFFSET_BITS = dlms_pkg::DEF_OFFSET_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire dlms_pkg::t_trk_cmd i_cmd,
    output logic                    o_hold,
    dlms_out_if.source              o_out
);
    import dlms_pkg::*;

    logic                   r_best_vld;
    logic [TAG_W-1:0]       r_best_tag;
    logic [OFFSET_BITS-1:0] r_best_pos;
    logic [OFFSET_BITS-1:0] r_run_pos;
    logic                   r_out_valid;
    logic                   r_matched;
    logic [TAG_W-1:0]       r_tag;
    logic [OUT_OFF_W-1:0]   r_off;

    logic adv;
    logic take;

    // a closing run cannot land while a result is still waiting
    assign o_hold = i_cmd.valid && i_cmd.end_run && r_out_valid && !o_out.ready;
    assign adv    = !o_hold;
    assign take   = adv && i_cmd.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_vld  <= 1'b0;
            r_run_pos   <= '0;
            r_best_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && i_cmd.end_run) begin
                // a new result replaces the one leaving in the same cycle
                r_out_valid <= 1'b1;
                r_best_vld  <= 1'b0;
                r_run_pos   <= '0;
                r_best_pos  <= '0;
            end else begin
                if (r_out_valid && o_out.ready) begin
                    r_out_valid <= 1'b0;
                end
                if (take && i_cmd.step) begin
                    if (!i_cmd.acc[VALUE_W-1]) begin
                        r_best_vld <= 1'b1;
                        r_best_pos <= r_run_pos;
                    end
                    if (r_run_pos != '1) begin
                        r_run_pos <= r_run_pos + 1'b1;
                    end
                end
            end
        end
    end

    // payload: tag and result fields
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.step && !i_cmd.acc[VALUE_W-1]) begin
            r_best_tag <= i_cmd.acc[TAG_W-1:0];
        end
        if (take && i_cmd.end_run) begin
            r_matched <= r_best_vld;
            r_tag     <= r_best_vld ? r_best_tag : '0;
            r_off     <= r_best_vld ? OUT_OFF_W'(r_best_pos) : '0;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_matched;
    assign o_out.pattern_tag      = r_tag;
    assign o_out.match_end_offset = r_off;

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.end_run) |=> (r_out_valid && !r_best_vld && r_run_pos == '0))
        else $error("run end did not clear the match record");

    a_step_records: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.step && !i_cmd.acc[VALUE_W-1] && !i_cmd.end_run)
        |=> (r_best_vld && r_best_tag == $past(i_cmd.acc[TAG_W-1:0])))
        else $error("accepting step not recorded");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_matched) |-> (r_tag == '0 && r_off == '0))
        else $error("unmatched result carries tag or offset");

endmodule

`default_nettype wire

>>> hdl/dfa_longest_match_scanner.sv
// dfa_longest_match_scanner: table-driven dfa lexer with longest-match tracking
// result path: the closing scan byte passes stages a, b and c, then the tracker registers the result on o_out
// throughput: one transaction per cycle unless a result is blocked at o_out, set by the
// transition read loop in which the registered read of the transition memory forms the next read address
// reset: synchronous, active low; clears the pipeline, dfa state and match record,
// the three tables keep their contents and hold no defined value until loaded
// depends on dlms_pkg, dlms_if and dlms_tracker
`default_nettype none

module dfa_longest_match_scanner #(
    parameter int NUM_STATES  = dlms_pkg::DEF_NUM_STATES,
    parameter int NUM_CLASSES = dlms_pkg::DEF_NUM_CLASSES,
    parameter int OFFSET_BITS = dlms_pkg::DEF_OFFSET_BITS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dlms_in_if.sink     i_in,
    dlms_out_if.source  o_out
);
    import dlms_pkg::*;

    localparam int SB = $clog2(NUM_STATES);
    localparam int CB = $clog2(NUM_CLASSES);
    localparam int TD = 1 << (SB + CB);

    // ---------------------------------------------------------------
    // table memories, written by load transactions in the stage where
    // the matching read happens so loads and scans stay in order
    // ---------------------------------------------------------------
    logic [CLASS_IDX_W-1:0] r_class_mem [256];
    logic [VALUE_W-1:0]     r_trans_mem [TD];
    logic [VALUE_W-1:0]     r_acc_mem   [NUM_STATES];

    // stage a: accepted transaction plus class lookup
    logic                   r_a_valid;
    t_op                    r_a_op;
    logic [STATE_IDX_W-1:0] r_a_sidx;
    logic [CLASS_IDX_W-1:0] r_a_cidx;
    logic [VALUE_W-1:0]     r_a_val;
    logic                   r_a_zero;
    logic [CLASS_IDX_W-1:0] r_a_cls;

    // stage b: transition read data
    logic                   r_b_valid;
    t_op                    r_b_op;
    logic [STATE_IDX_W-1:0] r_b_sidx;
    logic [VALUE_W-1:0]     r_b_val;
    logic                   r_b_zero;
    logic                   r_b_lookup;
    logic [VALUE_W-1:0]     r_tq;

    // committed dfa state after the item in stage b, when it made no lookup
    logic [SB-1:0]          r_state;

    // stage c: accept read data
    logic                   r_c_valid;
    logic                   r_c_step;
    logic                   r_c_end;
    logic [VALUE_W-1:0]     r_acc;

    logic                   adv;
    logic                   trk_hold;
    t_trk_cmd               trk_cmd;
    t_op                    in_op;
    logic                   in_take;
    logic                   tq_ok;
    logic [SB-1:0]          b_next;
    logic [SB-1:0]          cur_state;
    logic                   a_lookup;
    logic                   a_zero_scan;
    logic                   a_trans_wr;
    logic                   b_step;
    logic                   b_end;
    logic                   b_acc_wr;
    logic                   class_wr;

    // whole pipeline moves unless a finished result is blocked at the output
    assign adv        = !trk_hold;
    assign i_in.ready = adv;
    assign in_op      = t_op'(i_in.operation);
    assign in_take    = i_in.valid && adv;
    assign class_wr   = in_take && in_op == OP_LOAD_CLASS
                        && 32'(i_in.class_index) < NUM_CLASSES;

    // next state from the transition entry, none or out of range drops to state 0
    assign tq_ok     = !r_tq[VALUE_W-1] && (32'(r_tq[STATE_IDX_W-1:0]) < NUM_STATES);
    assign b_next    = tq_ok ? SB'(r_tq[STATE_IDX_W-1:0]) : '0;
    // state seen by the item in stage a: closes the state loop through the registered transition read
    assign cur_state = r_b_lookup ? b_next : r_state;

    assign a_lookup    = r_a_valid && r_a_op == OP_SCAN && !r_a_zero;
    assign a_zero_scan = r_a_valid && r_a_op == OP_SCAN && r_a_zero;
    assign a_trans_wr  = r_a_valid && r_a_op == OP_LOAD_TRANS
                         && 32'(r_a_sidx) < NUM_STATES && 32'(r_a_cidx) < NUM_CLASSES;

    assign b_step   = r_b_lookup && tq_ok;
    assign b_end    = r_b_valid && r_b_op == OP_SCAN && (r_b_zero || (r_b_lookup && !tq_ok));
    assign b_acc_wr = r_b_valid && r_b_op == OP_LOAD_ACCEPT && 32'(r_b_sidx) < NUM_STATES;

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_b_lookup <= 1'b0;
            r_state    <= '0;
            r_c_valid  <= 1'b0;
            r_c_step   <= 1'b0;
            r_c_end    <= 1'b0;
        end else if (adv) begin
            r_a_valid  <= i_in.valid;
            r_b_valid  <= r_a_valid;
            r_b_lookup <= a_lookup;
            r_state    <= a_zero_scan ? '0 : cur_state;
            r_c_valid  <= r_b_valid;
            r_c_step   <= b_step;
            r_c_end    <= b_end;
        end
    end

    // ---------------------------------------------------------------
    // payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_op   <= in_op;
            r_a_sidx <= i_in.state_index;
            r_a_cidx <= i_in.class_index;
            r_a_val  <= i_in.table_value;
            r_a_zero <= i_in.data_byte == '0;
            r_b_op   <= r_a_op;
            r_b_sidx <= r_a_sidx;
            r_b_val  <= r_a_val;
            r_b_zero <= r_a_zero;
        end
    end

    // class map: byte to class, read at acceptance
    always_ff @(posedge i_clk) begin
        if (class_wr) begin
            r_class_mem[i_in.data_byte] <= i_in.class_index;
        end
        if (adv) begin
            r_a_cls <= r_class_mem[i_in.data_byte];
        end
    end

    // transition memory: {state, class} to next state
    always_ff @(posedge i_clk) begin
        if (adv && a_trans_wr) begin
            r_trans_mem[{SB'(r_a_sidx), CB'(r_a_cidx)}] <= r_a_val;
        end
        if (adv && a_lookup) begin
            r_tq <= r_trans_mem[{cur_state, CB'(r_a_cls)}];
        end
    end

    // accept memory: state to pattern tag
    always_ff @(posedge i_clk) begin
        if (adv && b_acc_wr) begin
            r_acc_mem[SB'(r_b_sidx)] <= r_b_val;
        end
        if (adv && b_step) begin
            r_acc <= r_acc_mem[b_next];
        end
    end

    // ---------------------------------------------------------------
    // match record and result register
    // ---------------------------------------------------------------
    assign trk_cmd.valid   = r_c_valid;
    assign trk_cmd.step    = r_c_step;
    assign trk_cmd.end_run = r_c_end;
    assign trk_cmd.acc     = r_acc;

    dlms_tracker #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_tracker (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (trk_cmd),
        .o_hold  (trk_hold),
        .o_out   (o_out)
    );

    a_zero_resets_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && a_zero_scan) |=> (r_state == '0 && !r_b_lookup))
        else $error("zero byte did not return the dfa to state 0");

    a_hold_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trk_hold |=> (r_c_valid && r_c_end))
        else $error("blocked run end left stage c");

    a_step_xor_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_step |-> (!r_c_end && r_c_valid))
        else $error("stage c marks both step and run end");

    a_lookup_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_b_lookup) |-> (r_b_valid && r_b_op == OP_SCAN && !r_b_zero))
        else $error("transition lookup without a scan byte");

endmodule

`default_nettype wire

>>> tb/dfa_longest_match_scanner_test.sv
// dfa_longest_match_scanner_test: self-checking testbench of the dfa longest-match scanner
// predicts every run result from its own copy of the tables and the match record
// depends on dlms_pkg, dlms_if and the scanner rtl
`timescale 1ns / 100ps

module dfa_longest_match_scanner_test;
    import dlms_pkg::*;

    localparam int N_STATES     = DEF_NUM_STATES;
    localparam int N_CLASSES    = DEF_NUM_CLASSES;
    localparam longint unsigned OFFSET_MAX = (64'd1 << DEF_OFFSET_BITS) - 64'd1;
    localparam int RANDOM_ITEMS = 1600;
    localparam int LONG_RUN_LEN = 300;     // carries the offset past eight bits
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int STALL_PCT    = 30;

    // one input transaction
    typedef struct {
        t_op                       op;
        logic [STATE_IDX_W-1:0]    state_index;
        logic [CLASS_IDX_W-1:0]    class_index;
        logic signed [VALUE_W-1:0] table_value;
        logic [BYTE_W-1:0]         data_byte;
    } t_lex_item;

    // one run result
    typedef struct {
        logic                 matched;
        logic [TAG_W-1:0]     tag;
        logic [OUT_OFF_W-1:0] offset;
    } t_match;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dlms_in_if  in_ch ();
    dlms_out_if out_ch ();

    dfa_longest_match_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // lexer predictor: own copy of the three tables and the run record
    // ------------------------------------------------------------------
    logic signed [VALUE_W-1:0] trans_mem    [0:N_STATES*N_CLASSES-1];
    bit                        trans_known  [0:N_STATES*N_CLASSES-1];
    logic signed [VALUE_W-1:0] accept_mem   [0:N_STATES-1];
    bit                        accept_known [0:N_STATES-1];
    logic [CLASS_IDX_W-1:0]    class_mem    [0:255];
    bit                        class_known  [0:255];

    logic [STATE_IDX_W-1:0]    cur_state = '0;
    logic signed [VALUE_W-1:0] best_tag  = -9'sd1;
    longint unsigned           run_pos   = 0;
    longint unsigned           best_pos  = 0;

    t_match expected_matches [$];
    int     failures    = 0;
    int     items_sent  = 0;
    int     cycle_count = 0;
    bit     throttle    = 1'b1;   // random idling on both channels

    // states and classes that random loads favor, so runs get deep
    logic [STATE_IDX_W-1:0] active_states  [8];
    logic [CLASS_IDX_W-1:0] active_classes [6];

    // emit the run result and clear the record
    function automatic t_match close_run();
        t_match r;
        if (best_tag >= 0) begin
            r.matched = 1'b1;
            r.tag     = best_tag[TAG_W-1:0];
            r.offset  = best_pos[OUT_OFF_W-1:0];
        end else begin
            r = '{1'b0, '0, '0};
        end
        cur_state = '0;
        best_tag  = -9'sd1;
        run_pos   = 0;
        best_pos  = 0;
        return r;
    endfunction

    // applies one accepted transaction, returns 1 when it closes a run
    function automatic bit predict_lexer(input t_lex_item it, output t_match res);
        int                        idx;
        logic signed [VALUE_W-1:0] nxt;
        res = '{1'b0, '0, '0};
        case (it.op)
            OP_LOAD_TRANS: begin
                if (int'(it.state_index) < N_STATES && int'(it.class_index) < N_CLASSES) begin
                    idx = int'(it.state_index) * N_CLASSES + int'(it.class_index);
                    trans_mem[idx]   = it.table_value;
                    trans_known[idx] = 1'b1;
                end
                return 1'b0;
            end
            OP_LOAD_ACCEPT: begin
                if (int'(it.state_index) < N_STATES) begin
                    accept_mem[it.state_index]   = it.table_value;
                    accept_known[it.state_index] = 1'b1;
                end
                return 1'b0;
            end
            OP_LOAD_CLASS: begin
                if (int'(it.class_index) < N_CLASSES) begin
                    class_mem[it.data_byte]   = it.class_index;
                    class_known[it.data_byte] = 1'b1;
                end
                return 1'b0;
            end
            default: begin
                // zero byte closes the run without any lookup
                if (it.data_byte == '0) begin
                    res = close_run();
                    return 1'b1;
                end
                idx = int'(cur_state) * N_CLASSES + int'(class_mem[it.data_byte]);
                nxt = trans_mem[idx];
                // missing transition consumes the byte and closes the run
                if (nxt < 0 || nxt >= N_STATES) begin
                    res = close_run();
                    return 1'b1;
                end
                cur_state = nxt[STATE_IDX_W-1:0];
                if (accept_mem[cur_state] >= 0) begin
                    best_tag = accept_mem[cur_state];
                    best_pos = run_pos;
                end
                if (run_pos < OFFSET_MAX)
                    run_pos++;
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_lex_item make_item(input t_op op, input int unsigned s,
                                            input int unsigned c, input int v,
                                            input int unsigned b);
        t_lex_item it;
        it.op          = op;
        it.state_index = STATE_IDX_W'(s);
        it.class_index = CLASS_IDX_W'(c);
        it.table_value = VALUE_W'(v);
        it.data_byte   = BYTE_W'(b);
        return it;
    endfunction

    function automatic logic [CLASS_IDX_W-1:0] pick_class();
        if ($urandom_range(99) < 70)
            return active_classes[$urandom_range(5)];
        return CLASS_IDX_W'($urandom_range(N_CLASSES - 1));
    endfunction

    function automatic logic [STATE_IDX_W-1:0] pick_state();
        if ($urandom_range(99) < 85)
            return active_states[$urandom_range(7)];
        return STATE_IDX_W'($urandom_range(N_STATES - 1));
    endfunction

    // next state for a transition load, sometimes none (any negative value)
    function automatic logic signed [VALUE_W-1:0] pick_next();
        if ($urandom_range(99) < 15)
            return -VALUE_W'($urandom_range(256, 1));
        return VALUE_W'(pick_state());
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_tag();
        if ($urandom_range(99) < 50)
            return -VALUE_W'($urandom_range(256, 1));
        return VALUE_W'($urandom_range(255));
    endfunction

    task automatic choose_active_sets();
        active_states[0] = '0;   // every run starts in state 0
        for (int i = 1; i < 8; i++)
            active_states[i] = STATE_IDX_W'($urandom_range(N_STATES - 1));
        for (int i = 0; i < 6; i++)
            active_classes[i] = CLASS_IDX_W'($urandom_range(N_CLASSES - 1));
    endtask

    // drives one transaction from the falling edge, returns after the handshake
    task automatic send_item(input t_lex_item it);
        t_match r;
        @(negedge i_clk);
        while (throttle && $urandom_range(99) < STALL_PCT) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.operation   = it.op;
        in_ch.state_index = it.state_index;
        in_ch.class_index = it.class_index;
        in_ch.table_value = it.table_value;
        in_ch.data_byte   = it.data_byte;
        in_ch.valid       = 1'b1;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        if (predict_lexer(it, r))
            expected_matches = {expected_matches, r};
        items_sent++;
    endtask

    // scans one byte, first loading whatever table entry the step would read unwritten
    task automatic scan_byte(input logic [7:0] b);
        int                        idx;
        logic signed [VALUE_W-1:0] nxt;
        if (b != '0) begin
            if (!class_known[b])
                send_item(make_item(OP_LOAD_CLASS, $urandom, pick_class(), $urandom, b));
            idx = int'(cur_state) * N_CLASSES + int'(class_mem[b]);
            if (!trans_known[idx])
                send_item(make_item(OP_LOAD_TRANS, cur_state, class_mem[b], pick_next(),
                                    $urandom));
            nxt = trans_mem[idx];
            if (nxt >= 0 && !accept_known[nxt[STATE_IDX_W-1:0]])
                send_item(make_item(OP_LOAD_ACCEPT, nxt[STATE_IDX_W-1:0], $urandom,
                                    pick_tag(), $urandom));
        end
        send_item(make_item(OP_SCAN, $urandom, $urandom, $urandom, b));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty run, field extremes, tag 0, loads inside a run, missing transitions
    task automatic test_directed_runs();
        scan_byte(8'h00);                                      // empty run, no match
        send_item(make_item(OP_LOAD_CLASS, 0, 6'd63, 0, 8'hFF));
        send_item(make_item(OP_LOAD_CLASS, 0, 6'd0, 0, 8'h01));
        send_item(make_item(OP_LOAD_CLASS, 0, 6'd42, 0, 8'h80));
        send_item(make_item(OP_LOAD_TRANS, 8'd0, 6'd63, 9'sd255, 0));
        send_item(make_item(OP_LOAD_TRANS, 8'd255, 6'd0, 9'sd170, 0));
        send_item(make_item(OP_LOAD_TRANS, 8'd170, 6'd42, -9'sd256, 0));
        send_item(make_item(OP_LOAD_TRANS, 8'd255, 6'd63, -9'sd1, 0));
        send_item(make_item(OP_LOAD_ACCEPT, 8'd255, 0, 9'sd255, 0));
        send_item(make_item(OP_LOAD_ACCEPT, 8'd170, 0, -9'sd1, 0));
        scan_byte(8'hFF);                                      // accepting, tag 255
        scan_byte(8'h01);                                      // non-accepting step
        // rewriting the tag mid-run must not change the recorded match
        send_item(make_item(OP_LOAD_ACCEPT, 8'd255, 0, 9'sd0, 0));
        scan_byte(8'h80);                                      // missing transition closes
        scan_byte(8'hFF);                                      // match with tag 0
        scan_byte(8'h00);
        send_item(make_item(OP_LOAD_TRANS, 8'd0, 6'd0, 9'sd0, 0));
        send_item(make_item(OP_LOAD_ACCEPT, 8'd0, 0, 9'sd85, 0));
        send_item(make_item(OP_LOAD_TRANS, 8'd0, 6'd42, -9'sd1, 0));
        scan_byte(8'h01);
        scan_byte(8'h01);
        scan_byte(8'hFF);
        scan_byte(8'hFF);                                      // longest match at offset 2
        scan_byte(8'h80);                                      // first byte has no transition
    endtask

    // one long accepting run carries the offset past eight bits
    task automatic test_long_run();
        t_lex_item step;
        throttle = 1'b0;
        scan_byte(8'h00);
        send_item(make_item(OP_LOAD_CLASS, 0, 6'd0, 0, 8'h01));
        send_item(make_item(OP_LOAD_TRANS, 8'd0, 6'd0, 9'sd0, 0));
        send_item(make_item(OP_LOAD_ACCEPT, 8'd0, 0, 9'sd85, 0));
        step = make_item(OP_SCAN, 0, 0, 0, 8'h01);
        repeat (LONG_RUN_LEN) send_item(step);
        scan_byte(8'h00);
        throttle = 1'b1;
    endtask

    // mostly well-formed scanning on a few favored states, with stray loads mixed in
    task automatic test_random_scanning();
        int start;
        int done;
        int phase;
        int last_phase;
        int pick;
        start      = items_sent;
        last_phase = -1;
        done       = 0;
        while (done < RANDOM_ITEMS) begin
            phase = done / 400;
            if (phase != last_phase) begin
                choose_active_sets();
                last_phase = phase;
            end
            // stretch with no idling at all
            throttle = !(done >= 800 && done < 1100);
            pick = $urandom_range(99);
            if (pick < 8)
                scan_byte(8'h00);
            else if (pick < 85)
                scan_byte(8'($urandom_range(255, 1)));
            else if (pick < 90)
                send_item(make_item(OP_LOAD_CLASS, $urandom, pick_class(), $urandom,
                                    $urandom));
            else if (pick < 95)
                send_item(make_item(OP_LOAD_TRANS, pick_state(), pick_class(), pick_next(),
                                    $urandom));
            else
                send_item(make_item(OP_LOAD_ACCEPT, pick_state(), $urandom, pick_tag(),
                                    $urandom));
            done = items_sent - start;
        end
        throttle = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // result side: random backpressure and the checker
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_ch.ready = !throttle || ($urandom_range(99) >= STALL_PCT);
    end

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("%s", msg);
    endtask

    t_match want;

    // compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_matches.size() == 0) begin
                report_failure($sformatf("unexpected result: matched %0b tag %0d offset %0d",
                    out_ch.matched, out_ch.pattern_tag, out_ch.match_end_offset));
            end else begin
                want = expected_matches.pop_front();
                if (out_ch.matched !== want.matched || out_ch.pattern_tag !== want.tag ||
                    out_ch.match_end_offset !== want.offset)
                    report_failure($sformatf(
                        "result mismatch: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                        want.matched, want.tag, want.offset, out_ch.matched,
                        out_ch.pattern_tag, out_ch.match_end_offset));
            end
        end
    end

    // hard stop if the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.operation   = OP_SCAN;
        in_ch.state_index = '0;
        in_ch.class_index = '0;
        in_ch.table_value = '0;
        in_ch.data_byte   = '0;
        choose_active_sets();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_runs();
        test_long_run();
        test_random_scanning();

        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> dfa_longest_match_scanner.f
hdl/dlms_pkg.sv
hdl/dlms_if.sv
hdl/dlms_tracker.sv
hdl/dfa_longest_match_scanner.sv
tb/dfa_longest_match_scanner_test.sv
